FILE: sv/assert_macros.svh
// Assertion macros used by the checker of the palette mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/apcm_pkg.sv
// Types and constants shared by the adaptive palette colour mapper.
`default_nettype none

package apcm_pkg;

   // Field widths fixed by the pixel and result words.
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned SQ_W    = 2 * CHAN_W;
   localparam int unsigned DIST_W  = SQ_W + 2;

   // Starting bound for the nearest-colour search; above any real distance.
   localparam logic [DIST_W-1:0] DIST_INIT = '1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   // Search token that walks along the row of palette cells.
   typedef struct packed {
      rgb_type            color;
      logic               found;
      logic [INDEX_W-1:0] found_idx;
      logic [DIST_W-1:0]  best_dist;
      logic [INDEX_W-1:0] best_idx;
   } tok_type;

   // Broadcast write into one palette cell.
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] idx;
      rgb_type            color;
   } wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

`default_nettype wire

FILE: sv/apcm_channels.sv
// Handshake channel interfaces for pixel words and result words.
`default_nettype none

interface apcm_req_if;
   logic       valid;
   logic       ready;
   logic       new_image;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, new_image, red, green, blue, input ready);
   modport sink   (input valid, new_image, red, green, blue, output ready);
endinterface

interface apcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] color_index;
   logic       added;
   logic       approximate;
   logic [8:0] color_count;

   modport source (output valid, color_index, added, approximate, color_count,
                   input ready);
   modport sink   (input valid, color_index, added, approximate, color_count,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/adaptive_palette_color_mapper.sv
// Top level of the adaptive palette colour mapper: controller and cell row.
//
//   Channel   Direction  Word carried
//   req_ch    in         new_image, red, green, blue
//   rsp_ch    out        color_index, added, approximate, color_count
//
// One pixel is in flight at a time; its result word is offered on rsp_ch once
// the search token has stepped through the row, one palette cell per cycle, and
// the finished search has been loaded into the output register.
// A further pixel can be accepted the cycle after the result is loaded, even while
// that result still waits on rsp_ch.
// Reset clears the entry count and the valid flags; palette cells are not cleared.
// A stalled rsp_ch holds the finished search until the output register frees.
`default_nettype none

module adaptive_palette_color_mapper #(
   parameter int unsigned PALETTE_SIZE = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   apcm_req_if.sink   req_ch,
   apcm_rsp_if.source rsp_ch
);
   import apcm_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(PALETTE_SIZE);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               head_vld_ff, head_vld_in;
   tok_type            head_ff, head_in;
   tok_type            fin_ff;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic               rsp_add_ff, rsp_add_in;
   logic               rsp_apx_ff, rsp_apx_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic               load;
   logic               accept;
   wr_type             wr;

   logic               vld_chain [0:PALETTE_SIZE];
   tok_type            tok_chain [0:PALETTE_SIZE];

   assign accept = req_ch.valid && req_ch.ready;

   // Row of palette cells; each passes the token to the next every cycle.
   assign vld_chain[0] = head_vld_ff;
   assign tok_chain[0] = head_ff;

   for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
      apcm_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .used      (count_ff),
         .wr        (wr),
         .tok_vld_i (vld_chain[i]),
         .tok_i     (tok_chain[i]),
         .tok_vld_o (vld_chain[i+1]),
         .tok_o     (tok_chain[i+1])
      );
   end

   // Launch token built from the accepted pixel word.
   always_comb begin
      head_vld_in           = accept;
      head_in.color.red     = req_ch.red;
      head_in.color.green   = req_ch.green;
      head_in.color.blue    = req_ch.blue;
      head_in.found         = 1'b0;
      head_in.found_idx     = '0;
      head_in.best_dist     = DIST_INIT;
      head_in.best_idx      = '0;
   end

   // Controller: next state, count, palette append and result word.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      load       = 1'b0;
      wr.en      = 1'b0;
      wr.idx     = count_ff[INDEX_W-1:0];
      wr.color   = fin_ff.color;
      rsp_idx_in = fin_ff.best_idx;
      rsp_add_in = 1'b0;
      rsp_apx_in = 1'b0;
      rsp_cnt_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = req_ch.new_image ? '0 : count_ff;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (vld_chain[PALETTE_SIZE]) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               priority if (fin_ff.found) begin
                  rsp_idx_in = fin_ff.found_idx;
               end else if (count_ff != FULL_COUNT) begin
                  wr.en      = 1'b1;
                  rsp_idx_in = count_ff[INDEX_W-1:0];
                  rsp_add_in = 1'b1;
                  count_in   = count_ff + COUNT_W'(1);
                  rsp_cnt_in = count_ff + COUNT_W'(1);
               end else begin
                  rsp_apx_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output word valid: set on load, cleared once taken.
   always_comb begin
      if (load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         head_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         head_vld_ff <= head_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      if (vld_chain[PALETTE_SIZE]) begin
         fin_ff <= tok_chain[PALETTE_SIZE];
      end
      if (load) begin
         rsp_idx_ff <= rsp_idx_in;
         rsp_add_ff <= rsp_add_in;
         rsp_apx_ff <= rsp_apx_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.color_index = rsp_idx_ff;
   assign rsp_ch.added       = rsp_add_ff;
   assign rsp_ch.approximate = rsp_apx_ff;
   assign rsp_ch.color_count = rsp_cnt_ff;

endmodule

`default_nettype wire

FILE: sv/apcm_cell.sv
// One palette cell: holds an entry and updates the passing search token.
`default_nettype none

module apcm_cell #(
   parameter int unsigned CELL_IDX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [8:0]       used,
   input  wire apcm_pkg::wr_type wr,
   input  wire logic             tok_vld_i,
   input  wire apcm_pkg::tok_type tok_i,
   output logic                  tok_vld_o,
   output apcm_pkg::tok_type     tok_o
);
   import apcm_pkg::*;

   localparam logic [COUNT_W-1:0] MY_IDX = COUNT_W'(CELL_IDX);

   rgb_type           entry_ff;
   logic              tok_vld_ff;
   tok_type           tok_ff;
   tok_type           tok_in;
   logic              active;
   logic [CHAN_W-1:0] dr, dg, db;
   logic [SQ_W-1:0]   sqr, sqg, sqb;
   logic [DIST_W-1:0] sq_dist;

   // Entry store, written when the broadcast index selects this cell.
   always_ff @(posedge clock) begin
      if (wr.en && (COUNT_W'(wr.idx) == MY_IDX)) begin
         entry_ff <= wr.color;
      end
   end

   // Squared RGB distance between the token colour and this entry.
   always_comb begin
      dr   = (tok_i.color.red > entry_ff.red) ? tok_i.color.red - entry_ff.red
                                              : entry_ff.red - tok_i.color.red;
      dg   = (tok_i.color.green > entry_ff.green) ? tok_i.color.green - entry_ff.green
                                                  : entry_ff.green - tok_i.color.green;
      db   = (tok_i.color.blue > entry_ff.blue) ? tok_i.color.blue - entry_ff.blue
                                                : entry_ff.blue - tok_i.color.blue;
      sqr  = dr * dr;
      sqg  = dg * dg;
      sqb  = db * db;
      sq_dist = DIST_W'(sqr) + DIST_W'(sqg) + DIST_W'(sqb);
   end

   // Token update: first exact match wins, strict compare keeps the lowest index.
   always_comb begin
      active = MY_IDX < used;
      tok_in = tok_i;
      if (active) begin
         if (!tok_i.found && (entry_ff == tok_i.color)) begin
            tok_in.found     = 1'b1;
            tok_in.found_idx = MY_IDX[INDEX_W-1:0];
         end
         if (sq_dist < tok_i.best_dist) begin
            tok_in.best_dist = sq_dist;
            tok_in.best_idx  = MY_IDX[INDEX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff <= 1'b0;
      end else begin
         tok_vld_ff <= tok_vld_i;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   assign tok_vld_o = tok_vld_ff;
   assign tok_o     = tok_ff;

endmodule

`default_nettype wire

FILE: sv/apcm_checker.sv
// Port-level checker for the palette mapper and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module apcm_checker #(
   parameter int unsigned PALETTE_SIZE = 256
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] color_index,
   input wire logic       added,
   input wire logic       approximate,
   input wire logic [8:0] color_count
);

   // A waiting result word stays offered until taken.
   `ASSERT_IMPLIES_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")

   // Only one pixel is in the search at a time.
   `ASSERT_IMPLIES_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second pixel accepted during a search")

   // A pixel is either appended, approximated or matched exactly.
   `ASSERT_IMPLIES(a_flags_exclusive, clock, reset, rsp_valid, !(added && approximate), "added and approximate both set")

   // An appended colour takes the last slot of the grown palette.
   `ASSERT_IMPLIES(a_added_index, clock, reset, rsp_valid && added, {1'b0, color_index} == color_count - 9'd1, "appended index is not the last entry")

   // The count never passes the palette size, and approximation needs a full palette.
   `ASSERT_IMPLIES(a_count_bound, clock, reset, rsp_valid, (color_count <= 9'(PALETTE_SIZE)) && (!approximate || color_count == 9'(PALETTE_SIZE)), "palette count out of range")

endmodule

bind adaptive_palette_color_mapper apcm_checker #(
   .PALETTE_SIZE (PALETTE_SIZE)
) u_apcm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .color_index (rsp_ch.color_index),
   .added       (rsp_ch.added),
   .approximate (rsp_ch.approximate),
   .color_count (rsp_ch.color_count)
);

`default_nettype wire
